/* rtl/core/multilevel_ready_queue_defines.svh */
// Assertion macros for the ready queue checker.
`ifndef MULTILEVEL_READY_QUEUE_DEFINES_SVH
`define MULTILEVEL_READY_QUEUE_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define MRQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mrq check failed");

// Next-cycle implication, sampled on clk_i, off during reset.
`define MRQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mrq check failed");

`endif

/* rtl/core/mrq_pkg.sv */
package mrq_pkg;

  localparam int NUM_PRIORITIES = 32;
  localparam int MAX_TASKS      = 64;

  localparam int OP_W       = 2;
  localparam int TASK_W     = 6;
  localparam int PRIO_W     = 5;
  localparam int MASK_OUT_W = 32;

  localparam int MASK_W  = NUM_PRIORITIES;
  localparam int PRIO_AW = $clog2(NUM_PRIORITIES);
  localparam int LINK_AW = $clog2(MAX_TASKS);

  localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
  localparam logic [OP_W-1:0] OP_POP    = 2'd1;
  localparam logic [OP_W-1:0] OP_ROTATE = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic [TASK_W-1:0] task_id;
    logic [PRIO_W-1:0] priority_req;
  } in_t;

  typedef struct packed {
    logic [TASK_W-1:0]     head_task;
    logic                  head_valid;
    logic [MASK_OUT_W-1:0] nonempty_mask;
    logic [PRIO_W-1:0]     best_priority;
    logic                  any_ready;
    logic                  error;
  } out_t;

  typedef struct packed {
    logic [TASK_W-1:0] head;
    logic [TASK_W-1:0] tail;
  } ht_t;

endpackage

/* rtl/core/mrq_ram.sv */
module mrq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/multilevel_ready_queue.sv */
// Channel | Direction | Payload        | Handshake
// in      | input     | mrq_pkg::in_t  | in_valid_i / in_ready_o
// out     | output    | mrq_pkg::out_t | out_valid_o / out_ready_i
//
// Each transaction reads the head/tail table, then reads the link table,
// then writes back and loads the result register; both table reads are registered.
// A new transaction is taken while an earlier result still waits in the output register.
// A stalled output holds the block in its write-back cycle until the result is taken.
// Reset clears the non-empty mask and the control state; the tables need no clearing.
module multilevel_ready_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  mrq_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output mrq_pkg::out_t out_data_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_LOOK = 3'b010,
    ST_UPD  = 3'b100
  } state_e;

  state_e state_q, state_d;
  mrq_pkg::in_t  req_q;
  mrq_pkg::ht_t  ht_q, ht_rdata, ht_wdata;
  mrq_pkg::out_t out_q, out_d;
  logic out_valid_q, out_valid_d;
  logic [mrq_pkg::MASK_W-1:0] mask_q, mask_d, sel_bit;

  logic ht_we;
  logic lk_we;
  logic [mrq_pkg::LINK_AW-1:0] lk_waddr;
  logic [mrq_pkg::TASK_W-1:0]  lk_wdata, lk_rdata;
  logic [mrq_pkg::TASK_W-1:0]  h_look, t_look, head_new;

  logic in_acc, upd_go, prio_ok, task_ok, nonempty, nonempty_new;
  logic is_append, is_pop, is_rotate, app_ok, multi_look, multi_upd;

  function automatic logic [mrq_pkg::MASK_W-1:0] bit_of(logic [mrq_pkg::PRIO_W-1:0] p);
    logic [mrq_pkg::MASK_W-1:0] v;
    v = '0;
    for (int i = 0; i < mrq_pkg::NUM_PRIORITIES; i++) begin
      if (int'(p) == mrq_pkg::NUM_PRIORITIES - 1 - i) begin
        v[i] = 1'b1;
      end
    end
    return v;
  endfunction

  function automatic logic [mrq_pkg::PRIO_W-1:0] best_of(logic [mrq_pkg::MASK_W-1:0] m);
    logic [mrq_pkg::PRIO_W-1:0] b;
    b = '0;
    for (int i = 0; i < mrq_pkg::MASK_W; i++) begin
      if (m[i]) begin
        b = mrq_pkg::PRIO_W'(mrq_pkg::NUM_PRIORITIES - 1 - i);
      end
    end
    return b;
  endfunction

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign upd_go      = (state_q == ST_UPD) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign prio_ok   = int'(req_q.priority_req) < mrq_pkg::NUM_PRIORITIES;
  assign task_ok   = int'(req_q.task_id) < mrq_pkg::MAX_TASKS;
  assign sel_bit   = bit_of(req_q.priority_req);
  assign nonempty  = prio_ok && |(mask_q & sel_bit);
  assign is_append = (req_q.opcode == mrq_pkg::OP_APPEND);
  assign is_pop    = (req_q.opcode == mrq_pkg::OP_POP);
  assign is_rotate = (req_q.opcode == mrq_pkg::OP_ROTATE);
  assign app_ok    = is_append && prio_ok && task_ok;

  assign h_look     = ht_rdata.head;
  assign t_look     = ht_rdata.tail;
  assign multi_look = nonempty && (h_look != t_look);
  assign multi_upd  = nonempty && (ht_q.head != ht_q.tail);

  mrq_ram #(
    .WIDTH($bits(mrq_pkg::ht_t)),
    .DEPTH(mrq_pkg::NUM_PRIORITIES)
  ) u_ht_ram (
    .clk_i  (clk_i),
    .we_i   (ht_we),
    .waddr_i(mrq_pkg::PRIO_AW'(req_q.priority_req)),
    .wdata_i(ht_wdata),
    .re_i   (in_acc),
    .raddr_i(mrq_pkg::PRIO_AW'(in_data_i.priority_req)),
    .rdata_o(ht_rdata)
  );

  mrq_ram #(
    .WIDTH(mrq_pkg::TASK_W),
    .DEPTH(mrq_pkg::MAX_TASKS)
  ) u_link_ram (
    .clk_i  (clk_i),
    .we_i   (lk_we),
    .waddr_i(lk_waddr),
    .wdata_i(lk_wdata),
    .re_i   (state_q == ST_LOOK),
    .raddr_i(mrq_pkg::LINK_AW'(h_look)),
    .rdata_o(lk_rdata)
  );

  always_comb begin
    lk_we    = 1'b0;
    lk_waddr = mrq_pkg::LINK_AW'(req_q.task_id);
    lk_wdata = '0;
    if (state_q == ST_LOOK) begin
      if (app_ok) begin
        lk_we = 1'b1;
      end else if (is_rotate && multi_look) begin
        lk_we    = 1'b1;
        lk_waddr = mrq_pkg::LINK_AW'(t_look);
        lk_wdata = h_look;
      end
    end else if (upd_go) begin
      if (app_ok && nonempty) begin
        lk_we    = 1'b1;
        lk_waddr = mrq_pkg::LINK_AW'(ht_q.tail);
        lk_wdata = req_q.task_id;
      end else if ((is_pop && nonempty) || (is_rotate && multi_upd)) begin
        lk_we    = 1'b1;
        lk_waddr = mrq_pkg::LINK_AW'(ht_q.head);
      end
    end
  end

  always_comb begin
    ht_we    = 1'b0;
    ht_wdata = ht_q;
    mask_d   = mask_q;
    head_new = ht_q.head;
    if (app_ok) begin
      ht_we         = upd_go;
      head_new      = nonempty ? ht_q.head : req_q.task_id;
      ht_wdata.head = head_new;
      ht_wdata.tail = req_q.task_id;
      mask_d        = mask_q | sel_bit;
    end else if (is_pop && nonempty) begin
      if (multi_upd) begin
        ht_we         = upd_go;
        head_new      = lk_rdata;
        ht_wdata.head = lk_rdata;
      end else begin
        mask_d = mask_q & ~sel_bit;
      end
    end else if (is_rotate && multi_upd) begin
      ht_we         = upd_go;
      head_new      = lk_rdata;
      ht_wdata.head = lk_rdata;
      ht_wdata.tail = ht_q.head;
    end
  end

  assign nonempty_new = prio_ok && |(mask_d & sel_bit);

  always_comb begin
    out_d.head_task     = nonempty_new ? head_new : '0;
    out_d.head_valid    = nonempty_new;
    out_d.nonempty_mask = mrq_pkg::MASK_OUT_W'(mask_d);
    out_d.best_priority = best_of(mask_d);
    out_d.any_ready     = |mask_d;
    out_d.error         = (is_pop || is_rotate) && !nonempty;
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_LOOK;
        end
      end
      ST_LOOK: begin
        state_d = ST_UPD;
      end
      ST_UPD: begin
        if (upd_go) begin
          state_d     = ST_IDLE;
          out_valid_d = 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      mask_q      <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (upd_go) begin
        mask_q <= mask_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q <= in_data_i;
    end
    if (state_q == ST_LOOK) begin
      ht_q <= ht_rdata;
    end
    if (upd_go) begin
      out_q <= out_d;
    end
  end

endmodule

/* rtl/core/mrq_checker.sv */
`include "multilevel_ready_queue_defines.svh"

module mrq_sva (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input mrq_pkg::out_t out_data_o
);

  logic best_bit;
  logic in_acc;

  assign in_acc   = in_valid_i && in_ready_o;
  assign best_bit = out_data_o.nonempty_mask[
                      mrq_pkg::NUM_PRIORITIES - 1 - int'(out_data_o.best_priority)];

  `MRQ_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o))
  `MRQ_ASSERT_NEXT(a_one_in_flight, in_acc, !in_ready_o)
  `MRQ_ASSERT_NOW(a_any_matches_mask, out_valid_o,
                  out_data_o.any_ready == (out_data_o.nonempty_mask != '0))
  `MRQ_ASSERT_NOW(a_best_is_set, out_valid_o && out_data_o.any_ready, best_bit)
  `MRQ_ASSERT_NOW(a_error_no_head, out_valid_o && out_data_o.error,
                  !out_data_o.head_valid && out_data_o.head_task == '0)

endmodule

bind multilevel_ready_queue mrq_sva u_mrq_sva (.*);
